FILE: sv/amu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amu_pkg - shared types and constants of the 6502 address mode unit
// Function codes, sequencing phases and the state and result records.
// ----------------------------------------------------------------------------
package amu_pkg;

	localparam logic [3:0] FN_IMPL = 4'd0;
	localparam logic [3:0] FN_IMM  = 4'd1;
	localparam logic [3:0] FN_ZP   = 4'd2;
	localparam logic [3:0] FN_ZPX  = 4'd3;
	localparam logic [3:0] FN_ZPY  = 4'd4;
	localparam logic [3:0] FN_ABS  = 4'd5;
	localparam logic [3:0] FN_ABSX = 4'd6;
	localparam logic [3:0] FN_ABSY = 4'd7;
	localparam logic [3:0] FN_IND  = 4'd8;
	localparam logic [3:0] FN_INDX = 4'd9;
	localparam logic [3:0] FN_INDY = 4'd10;
	localparam logic [3:0] FN_DATA = 4'd11;

	localparam logic [15:0] PAGE_MASK = 16'h00FF;

	localparam logic [15:0] LEN_TWO   = 16'd2;
	localparam logic [15:0] LEN_THREE = 16'd3;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_OP1    = 3'd1,
		PH_OP2    = 3'd2,
		PH_PTR_LO = 3'd3,
		PH_PTR_HI = 3'd4
	} phase_t;

	typedef struct packed {
		logic [3:0]  mode;
		logic [15:0] pc;
		logic [7:0]  x;
		logic [7:0]  y;
		phase_t      phase;
		logic [7:0]  low;
		logic [15:0] ptr;
	} amu_state_t;

	typedef struct packed {
		logic        has_res;
		logic        done;
		logic [15:0] address;
		logic [15:0] next_pc;
	} amu_result_t;

endpackage : amu_pkg
`default_nettype wire

FILE: sv/cpu6502_address_mode_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpu6502_address_mode_unit - 6502 effective address sequencer
// Issues operand and pointer read requests and returns the effective address
// and the PC of the following opcode for the eleven addressing modes.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------
//  input   | in_valid, in_ready  | func, pc, x, y, read_data
//  output  | out_valid, out_ready| done_res, address, next_pc
//
// One word is taken per cycle unless a waiting result stalls the input side; a
// result word is registered first in the input register, then in the result register.
// The step logic between those two registers sets the rate of one word a cycle.
// Reset clears the sequencer state, both valid flags and the phase to idle.
// A stalled result holds the input register; words that give no result still
// pass through while the result register waits.
// ----------------------------------------------------------------------------
module cpu6502_address_mode_unit import amu_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  func,
	input  wire logic [15:0] pc,
	input  wire logic [7:0]  x,
	input  wire logic [7:0]  y,
	input  wire logic [7:0]  read_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             done_res,
	output logic [15:0]      address,
	output logic [15:0]      next_pc
);

	logic        valid_s1;
	logic [3:0]  func_s1;
	logic [15:0] pc_s1;
	logic [7:0]  x_s1;
	logic [7:0]  y_s1;
	logic [7:0]  data_s1;

	amu_state_t  state_q;
	amu_state_t  state_nxt;
	amu_result_t res;

	logic        out_valid_q;
	logic        done_q;
	logic [15:0] address_q;
	logic [15:0] next_pc_q;
	logic        advance;

	amu_resolve u_resolve (
		.func      (func_s1),
		.pc        (pc_s1),
		.x         (x_s1),
		.y         (y_s1),
		.read_data (data_s1),
		.st        (state_q),
		.st_nxt    (state_nxt),
		.res       (res)
	);

	assign advance  = valid_s1 && (!out_valid_q || out_ready || !res.has_res);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			state_q     <= '{mode: '0, pc: '0, x: '0, y: '0, phase: PH_IDLE,
			                 low: '0, ptr: '0};
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				state_q <= state_nxt;
			if (advance && res.has_res)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1 <= func;
			pc_s1   <= pc;
			x_s1    <= x;
			y_s1    <= y;
			data_s1 <= read_data;
		end
		if (advance && res.has_res) begin
			done_q    <= res.done;
			address_q <= res.address;
			next_pc_q <= res.next_pc;
		end
	end

	assign out_valid = out_valid_q;
	assign done_res  = done_q;
	assign address   = address_q;
	assign next_pc   = next_pc_q;

endmodule : cpu6502_address_mode_unit
`default_nettype wire

FILE: sv/amu_resolve.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amu_resolve - one sequencing step of the address mode unit
// Takes one word and the current state, gives the next state and the result.
// ----------------------------------------------------------------------------
module amu_resolve import amu_pkg::*; (
	input  wire logic [3:0]  func,
	input  wire logic [15:0] pc,
	input  wire logic [7:0]  x,
	input  wire logic [7:0]  y,
	input  wire logic [7:0]  read_data,
	input  wire amu_state_t  st,
	output amu_state_t       st_nxt,
	output amu_result_t      res
);

	logic [15:0] word_addr;
	logic [15:0] ptr_next;
	logic [15:0] zp_x;
	logic [15:0] zp_y;

	assign word_addr = {read_data, st.low};
	assign ptr_next  = {st.ptr[15:8], st.ptr[7:0] + 8'd1};
	assign zp_x      = ({8'h00, read_data} + {8'h00, st.x}) & PAGE_MASK;
	assign zp_y      = ({8'h00, read_data} + {8'h00, st.y}) & PAGE_MASK;

	always_comb begin
		st_nxt = st;
		res    = '0;
		if (func <= FN_INDY) begin
			st_nxt.mode = func;
			st_nxt.pc   = pc;
			st_nxt.x    = x;
			st_nxt.y    = y;
			st_nxt.low  = '0;
			st_nxt.ptr  = '0;
			res.has_res = 1'b1;
			if (func == FN_IMPL) begin
				st_nxt.phase = PH_IDLE;
				res.done     = 1'b1;
				res.address  = '0;
				res.next_pc  = pc + 16'd1;
			end else if (func == FN_IMM) begin
				st_nxt.phase = PH_IDLE;
				res.done     = 1'b1;
				res.address  = pc + 16'd1;
				res.next_pc  = pc + 16'd2;
			end else begin
				st_nxt.phase = PH_OP1;
				res.address  = pc + 16'd1;
			end
		end else if (func == FN_DATA && st.phase != PH_IDLE) begin
			res.has_res = 1'b1;
			unique case (st.phase)
				PH_OP1: begin
					unique case (st.mode)
						FN_ZP: begin
							st_nxt.phase = PH_IDLE;
							res.done     = 1'b1;
							res.address  = {8'h00, read_data};
							res.next_pc  = st.pc + LEN_TWO;
						end
						FN_ZPX: begin
							st_nxt.phase = PH_IDLE;
							res.done     = 1'b1;
							res.address  = zp_x;
							res.next_pc  = st.pc + LEN_TWO;
						end
						FN_ZPY: begin
							st_nxt.phase = PH_IDLE;
							res.done     = 1'b1;
							res.address  = zp_y;
							res.next_pc  = st.pc + LEN_TWO;
						end
						FN_INDX: begin
							st_nxt.ptr   = zp_x;
							st_nxt.phase = PH_PTR_LO;
							res.address  = zp_x;
						end
						FN_INDY: begin
							st_nxt.ptr   = {8'h00, read_data};
							st_nxt.phase = PH_PTR_LO;
							res.address  = {8'h00, read_data};
						end
						default: begin
							st_nxt.low   = read_data;
							st_nxt.phase = PH_OP2;
							res.address  = st.pc + 16'd2;
						end
					endcase
				end
				PH_OP2: begin
					if (st.mode == FN_IND) begin
						st_nxt.ptr   = word_addr;
						st_nxt.phase = PH_PTR_LO;
						res.address  = word_addr;
					end else begin
						st_nxt.phase = PH_IDLE;
						res.done     = 1'b1;
						res.next_pc  = st.pc + LEN_THREE;
						if (st.mode == FN_ABSX)
							res.address = word_addr + {8'h00, st.x};
						else if (st.mode == FN_ABSY)
							res.address = word_addr + {8'h00, st.y};
						else
							res.address = word_addr;
					end
				end
				PH_PTR_LO: begin
					st_nxt.low   = read_data;
					st_nxt.phase = PH_PTR_HI;
					res.address  = ptr_next;
				end
				default: begin
					// Last pointer byte; JMP indirect counts three bytes of opcode.
					st_nxt.phase = PH_IDLE;
					res.done     = 1'b1;
					if (st.mode == FN_IND) begin
						res.address = word_addr;
						res.next_pc = st.pc + LEN_THREE;
					end else if (st.mode == FN_INDY) begin
						res.address = word_addr + {8'h00, st.y};
						res.next_pc = st.pc + LEN_TWO;
					end else begin
						res.address = word_addr;
						res.next_pc = st.pc + LEN_TWO;
					end
				end
			endcase
		end
	end

endmodule : amu_resolve
`default_nettype wire

FILE: sv/amu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amu_checker - port-level checks of the address mode unit
// Watches the top level's handshakes and result words.
// ----------------------------------------------------------------------------
module amu_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        done_res,
	input wire logic [15:0] address,
	input wire logic [15:0] next_pc
);

	// A held result keeps the output word.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(address) && $stable(next_pc)
			&& $stable(done_res))
		else $error("stalled result word changed");

	// The input side only stalls behind a waiting result.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty result register");

	// A read request carries no next PC.
	a_req_npc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> next_pc == 16'd0)
		else $error("read request with non-zero next PC");

	// A stall of the input side never follows a stall that had no waiting result.
	a_no_deadlock: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> !$past(!in_ready && !out_valid))
		else $error("input stalled without a waiting result");

endmodule : amu_checker

bind cpu6502_address_mode_unit amu_checker u_amu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.done_res  (done_res),
	.address   (address),
	.next_pc   (next_pc)
);
`default_nettype wire
